// ----- hdl/cau_pkg.sv -----
// cau_pkg: shared widths, operation codes, beat types and the saturation
// helper for the complex arithmetic unit. No dependencies.
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W;
    localparam int DIV_W     = MAG_W + DATA_W;
    localparam int DIV_BITS  = DATA_W;
    localparam int DIV_LAT   = DIV_BITS + 2;
    localparam int PIPE_LAT  = DIV_LAT + 4;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_re;
        logic signed [DATA_W-1:0] result_im;
        logic                     is_equal;
        logic                     divide_by_zero;
        logic                     overflowed;
    } res_t;

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  den;
    } div_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] q;
        logic              ovf;
    } div_out_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    function automatic sat_t sat_sum(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.val = SAT_HI[DATA_W-1:0];
            r.ovf = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            r.val = SAT_LO[DATA_W-1:0];
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/complex_arithmetic_unit.sv -----
// complex_arithmetic_unit: top level, complex add, subtract, multiply,
// divide and tolerance compare in signed fixed point. Uses cau_pkg, cau_divider.
//
// Takes one command per clock and never raises busy. Every command gives
// exactly one result beat on done, whatever the operation; all beats travel
// alongside the 32-stage restoring divider. The result port cannot be held off.
module complex_arithmetic_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cau_pkg::cmd_t               cmd,
    output logic                        done,
    output cau_pkg::res_t               result,
    input  logic                        cfg_we,
    input  logic [cau_pkg::TOL_W-1:0]   cfg_wdata
);

    typedef struct packed {
        logic [2:0]                 op;
        logic [cau_pkg::DATA_W-1:0] re;
        logic [cau_pkg::DATA_W-1:0] im;
        logic                       eq;
        logic                       ovf;
        logic                       dz;
    } sb_t;

    logic [cau_pkg::TOL_W-1:0] tol_reg;

    // stage 1
    logic                                s1_vld_reg;
    logic [2:0]                          s1_op_reg;
    logic signed [cau_pkg::PROD_W-1:0]   s1_prr_reg, s1_pii_reg, s1_pri_reg, s1_pir_reg;
    logic signed [cau_pkg::PROD_W-1:0]   s1_drr_reg, s1_dii_reg;
    logic [cau_pkg::DATA_W-1:0]          s1_asre_reg, s1_asim_reg;
    logic                                s1_asovf_reg, s1_eq_reg;
    cau_pkg::sat_t                       as_re_next, as_im_next;
    logic signed [cau_pkg::DATA_W:0]     dre_next, dim_next;
    logic [cau_pkg::DATA_W:0]            are_next, aim_next;

    // stage 2
    logic                                s2_vld_reg;
    logic [2:0]                          s2_op_reg;
    logic signed [cau_pkg::SUM_W-1:0]    s2_sum1_reg, s2_sum2_reg;
    logic [cau_pkg::MAG_W-1:0]           s2_den_reg;
    logic [cau_pkg::DATA_W-1:0]          s2_asre_reg, s2_asim_reg;
    logic                                s2_asovf_reg, s2_eq_reg;

    // stage 3
    logic                                s3_vld_reg;
    sb_t                                 s3_sb_reg, s3_sb_next;
    cau_pkg::div_in_t                    s3_dre_reg, s3_dim_reg;
    cau_pkg::sat_t                       mre_next, mim_next;
    logic                                n1_next, n2_next;

    sb_t                                 sb_reg  [0:cau_pkg::DIV_LAT-1];
    logic                                sbv_reg [0:cau_pkg::DIV_LAT-1];

    logic                                dre_vld, dim_vld;
    cau_pkg::div_out_t                   dre_out, dim_out;

    logic                                out_vld_reg;
    cau_pkg::res_t                       res_reg, res_next;
    sb_t                                 sb_last;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= cau_pkg::TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (cmd.operation == cau_pkg::OP_SUB)
        begin
            as_re_next = cau_pkg::sat_sum(cau_pkg::SUM_W'(cmd.a_re) - cau_pkg::SUM_W'(cmd.b_re));
            as_im_next = cau_pkg::sat_sum(cau_pkg::SUM_W'(cmd.a_im) - cau_pkg::SUM_W'(cmd.b_im));
        end
        else
        begin
            as_re_next = cau_pkg::sat_sum(cau_pkg::SUM_W'(cmd.a_re) + cau_pkg::SUM_W'(cmd.b_re));
            as_im_next = cau_pkg::sat_sum(cau_pkg::SUM_W'(cmd.a_im) + cau_pkg::SUM_W'(cmd.b_im));
        end
        dre_next = (cau_pkg::DATA_W+1)'(cmd.a_re) - (cau_pkg::DATA_W+1)'(cmd.b_re);
        dim_next = (cau_pkg::DATA_W+1)'(cmd.a_im) - (cau_pkg::DATA_W+1)'(cmd.b_im);
        are_next = dre_next[cau_pkg::DATA_W] ? -dre_next : dre_next;
        aim_next = dim_next[cau_pkg::DATA_W] ? -dim_next : dim_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= cmd.operation;
        s1_prr_reg   <= cmd.a_re * cmd.b_re;
        s1_pii_reg   <= cmd.a_im * cmd.b_im;
        s1_pri_reg   <= cmd.a_re * cmd.b_im;
        s1_pir_reg   <= cmd.a_im * cmd.b_re;
        s1_drr_reg   <= cmd.b_re * cmd.b_re;
        s1_dii_reg   <= cmd.b_im * cmd.b_im;
        s1_asre_reg  <= as_re_next.val;
        s1_asim_reg  <= as_im_next.val;
        s1_asovf_reg <= as_re_next.ovf | as_im_next.ovf;
        s1_eq_reg    <= (are_next < (cau_pkg::DATA_W+1)'(tol_reg))
                     && (aim_next < (cau_pkg::DATA_W+1)'(tol_reg));
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        if (s1_op_reg == cau_pkg::OP_MUL)
        begin
            s2_sum1_reg <= cau_pkg::SUM_W'(s1_prr_reg) - cau_pkg::SUM_W'(s1_pii_reg);
            s2_sum2_reg <= cau_pkg::SUM_W'(s1_pri_reg) + cau_pkg::SUM_W'(s1_pir_reg);
        end
        else
        begin
            s2_sum1_reg <= cau_pkg::SUM_W'(s1_prr_reg) + cau_pkg::SUM_W'(s1_pii_reg);
            s2_sum2_reg <= cau_pkg::SUM_W'(s1_pir_reg) - cau_pkg::SUM_W'(s1_pri_reg);
        end
        s2_den_reg   <= cau_pkg::MAG_W'(s1_drr_reg) + cau_pkg::MAG_W'(s1_dii_reg);
        s2_asre_reg  <= s1_asre_reg;
        s2_asim_reg  <= s1_asim_reg;
        s2_asovf_reg <= s1_asovf_reg;
        s2_eq_reg    <= s1_eq_reg;
    end

    always_comb
    begin
        mre_next = cau_pkg::sat_sum(s2_sum1_reg >>> cau_pkg::FRAC_BITS);
        mim_next = cau_pkg::sat_sum(s2_sum2_reg >>> cau_pkg::FRAC_BITS);
        n1_next  = s2_sum1_reg[cau_pkg::SUM_W-1];
        n2_next  = s2_sum2_reg[cau_pkg::SUM_W-1];
        s3_sb_next = '0;
        s3_sb_next.op = s2_op_reg;
        case (s2_op_reg)
            cau_pkg::OP_ADD,
            cau_pkg::OP_SUB:
            begin
                s3_sb_next.re  = s2_asre_reg;
                s3_sb_next.im  = s2_asim_reg;
                s3_sb_next.ovf = s2_asovf_reg;
            end
            cau_pkg::OP_MUL:
            begin
                s3_sb_next.re  = mre_next.val;
                s3_sb_next.im  = mim_next.val;
                s3_sb_next.ovf = mre_next.ovf | mim_next.ovf;
            end
            cau_pkg::OP_DIV:
            begin
                s3_sb_next.dz  = s2_den_reg == '0;
            end
            cau_pkg::OP_CMP:
            begin
                s3_sb_next.eq  = s2_eq_reg;
            end
            default:
            begin
                s3_sb_next.op  = s2_op_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s3_sb_reg      <= s3_sb_next;
        s3_dre_reg.neg <= n1_next;
        s3_dre_reg.mag <= n1_next ? cau_pkg::MAG_W'(-s2_sum1_reg)
                                  : cau_pkg::MAG_W'(s2_sum1_reg);
        s3_dre_reg.den <= s2_den_reg;
        s3_dim_reg.neg <= n2_next;
        s3_dim_reg.mag <= n2_next ? cau_pkg::MAG_W'(-s2_sum2_reg)
                                  : cau_pkg::MAG_W'(s2_sum2_reg);
        s3_dim_reg.den <= s2_den_reg;
    end

    cau_divider u_div_re (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .din       (s3_dre_reg),
        .out_valid (dre_vld),
        .dout      (dre_out)
    );

    cau_divider u_div_im (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .din       (s3_dim_reg),
        .out_valid (dim_vld),
        .dout      (dim_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cau_pkg::DIV_LAT; i++)
                sbv_reg[i] <= 1'b0;
        end
        else
        begin
            sbv_reg[0] <= s3_vld_reg;
            for (int i = 1; i < cau_pkg::DIV_LAT; i++)
                sbv_reg[i] <= sbv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= s3_sb_reg;
        for (int i = 1; i < cau_pkg::DIV_LAT; i++)
            sb_reg[i] <= sb_reg[i-1];
    end

    assign sb_last = sb_reg[cau_pkg::DIV_LAT-1];

    always_comb
    begin
        res_next.is_equal       = sb_last.eq;
        res_next.divide_by_zero = sb_last.dz;
        if (sb_last.op == cau_pkg::OP_DIV && !sb_last.dz)
        begin
            res_next.result_re  = dre_out.q;
            res_next.result_im  = dim_out.q;
            res_next.overflowed = dre_out.ovf | dim_out.ovf;
        end
        else
        begin
            res_next.result_re  = sb_last.re;
            res_next.result_im  = sb_last.im;
            res_next.overflowed = sb_last.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= sbv_reg[cau_pkg::DIV_LAT-1] & dre_vld & dim_vld;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = out_vld_reg;
    assign result = res_reg;

endmodule

// ----- hdl/cau_divider.sv -----
// cau_divider: pipelined restoring divider, one quotient bit per stage,
// giving a saturated signed fixed-point quotient. Depends on cau_pkg.
module cau_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cau_pkg::div_in_t    din,
    output logic                out_valid,
    output cau_pkg::div_out_t   dout
);

    logic [cau_pkg::DIV_W-1:0]  rem_reg   [0:cau_pkg::DIV_BITS];
    logic [cau_pkg::DATA_W-1:0] q_reg     [0:cau_pkg::DIV_BITS];
    logic [cau_pkg::MAG_W-1:0]  den_reg   [0:cau_pkg::DIV_BITS];
    logic                       neg_reg   [0:cau_pkg::DIV_BITS];
    logic                       pov_reg   [0:cau_pkg::DIV_BITS];
    logic                       vld_reg   [0:cau_pkg::DIV_BITS];

    logic [cau_pkg::DIV_W-1:0]  rem_next;
    logic [cau_pkg::DIV_W-1:0]  dtop_next;
    cau_pkg::div_out_t          dout_next;
    cau_pkg::div_out_t          dout_reg;
    logic                       out_vld_reg;

    // prep: scale numerator, flag quotients of 2^DATA_W and up
    always_comb
    begin
        rem_next  = cau_pkg::DIV_W'(din.mag) << cau_pkg::FRAC_BITS;
        dtop_next = cau_pkg::DIV_W'(din.den) << cau_pkg::DATA_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next;
        q_reg[0]   <= '0;
        den_reg[0] <= din.den;
        neg_reg[0] <= din.neg;
        pov_reg[0] <= rem_next >= dtop_next;
    end

    for (genvar k = 0; k < cau_pkg::DIV_BITS; k++)
    begin : g_stage
        localparam int SH = cau_pkg::DIV_BITS - 1 - k;
        logic [cau_pkg::DIV_W-1:0] dsh;
        logic                      take;

        always_comb
        begin
            dsh  = cau_pkg::DIV_W'(den_reg[k]) << SH;
            take = rem_reg[k] >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
            q_reg[k+1]   <= {q_reg[k][cau_pkg::DATA_W-2:0], take};
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            pov_reg[k+1] <= pov_reg[k];
        end
    end

    localparam int L = cau_pkg::DIV_BITS;
    localparam logic [cau_pkg::DATA_W-1:0] NEG_LIM = {1'b1, {(cau_pkg::DATA_W-1){1'b0}}};
    localparam logic [cau_pkg::DATA_W-1:0] POS_LIM = {1'b0, {(cau_pkg::DATA_W-1){1'b1}}};

    always_comb
    begin
        if (pov_reg[L])
        begin
            dout_next.q   = neg_reg[L] ? NEG_LIM : POS_LIM;
            dout_next.ovf = 1'b1;
        end
        else if (neg_reg[L])
        begin
            dout_next.ovf = q_reg[L] > NEG_LIM;
            dout_next.q   = dout_next.ovf ? NEG_LIM : (~q_reg[L] + 1'b1);
        end
        else
        begin
            dout_next.ovf = q_reg[L] > POS_LIM;
            dout_next.q   = dout_next.ovf ? POS_LIM : q_reg[L];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[L];
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign out_valid = out_vld_reg;
    assign dout      = dout_reg;

endmodule

// ----- hdl/cau_checker.sv -----
// cau_checker: port-level checks for complex_arithmetic_unit, bound to the
// top level. Depends on cau_pkg.
module cau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input cau_pkg::res_t result
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(cau_pkg::PIPE_LAT) done)
        else $error("command did not produce a result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, cau_pkg::PIPE_LAT))
        else $error("result beat without a command");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.divide_by_zero |-> result.result_re == '0
            && result.result_im == '0 && !result.overflowed && !result.is_equal)
        else $error("divide by zero beat not cleared");

    a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_equal |-> result.result_re == '0
            && result.result_im == '0 && !result.overflowed)
        else $error("compare beat carries data");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for complex_arithmetic_unit; directed table, then
// random bursts over several tolerance settings, checked by a local predictor.
// Depends on cau_pkg and the RTL of complex_arithmetic_unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RSV5 = 3'd5;
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_PHASE = 390;

    typedef struct {
        cau_pkg::cmd_t c;
        bit            typed;
        cau_pkg::res_t r;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cau_pkg::cmd_t cmd = '0;
    logic done;
    cau_pkg::res_t result;
    logic cfg_we = 1'b0;
    logic [cau_pkg::TOL_W-1:0] cfg_wdata = '0;

    logic [cau_pkg::TOL_W-1:0] tolerance = cau_pkg::TOL_RESET;
    cau_pkg::res_t pending_results[$];
    stim_row_t directed[$];
    int errors = 0;
    int cycles = 0;

    complex_arithmetic_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [32:0] clamp(input logic signed [81:0] v);
        if (v > 82'sd2147483647)
            return {1'b1, VMAX};
        else if (v < -82'sd2147483648)
            return {1'b1, VMIN};
        else
            return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] div_part(input logic signed [65:0] n,
                                             input logic [65:0] den);
        logic [81:0] mag;
        logic [81:0] q;
        mag = n < 0 ? 82'(-n) : 82'(n);
        q = (mag << cau_pkg::FRAC_BITS) / {16'b0, den};
        if (n < 0)
            return clamp(-$signed(q));
        else
            return clamp($signed(q));
    endfunction

    function automatic cau_pkg::res_t predict_result(input cau_pkg::cmd_t c,
                                                     input logic [cau_pkg::TOL_W-1:0] tol);
        cau_pkg::res_t r;
        logic signed [65:0] ar, ai, br, bi, s_re, s_im;
        logic [65:0] den, dr, di;
        logic [32:0] p_re, p_im;
        r = '0;
        ar = c.a_re;
        ai = c.a_im;
        br = c.b_re;
        bi = c.b_im;
        p_re = '0;
        p_im = '0;
        case (c.operation)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                s_re = c.operation == cau_pkg::OP_ADD ? ar + br : ar - br;
                s_im = c.operation == cau_pkg::OP_ADD ? ai + bi : ai - bi;
                p_re = clamp(82'(s_re));
                p_im = clamp(82'(s_im));
            end
            cau_pkg::OP_MUL:
            begin
                s_re = ar * br - ai * bi;
                s_im = ar * bi + ai * br;
                p_re = clamp(82'(s_re >>> cau_pkg::FRAC_BITS));
                p_im = clamp(82'(s_im >>> cau_pkg::FRAC_BITS));
            end
            cau_pkg::OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    p_re = div_part(ar * br + ai * bi, den);
                    p_im = div_part(ai * br - ar * bi, den);
                end
            end
            cau_pkg::OP_CMP:
            begin
                dr = ar >= br ? ar - br : br - ar;
                di = ai >= bi ? ai - bi : bi - ai;
                r.is_equal = dr < tol && di < tol;
            end
            default:
            begin
            end
        endcase
        r.result_re = p_re[31:0];
        r.result_im = p_im[31:0];
        r.overflowed = p_re[32] | p_im[32];
        return r;
    endfunction

    function automatic stim_row_t row(input logic [2:0] op, input logic signed [31:0] are,
                                      input logic signed [31:0] aim,
                                      input logic signed [31:0] bre,
                                      input logic signed [31:0] bim,
                                      input bit typed, input cau_pkg::res_t r);
        stim_row_t s;
        s.c = '{op, are, aim, bre, bim};
        s.typed = typed;
        s.r = r;
        return s;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            4: return $urandom_range(0, 1) ? ONE : -ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] near(input logic signed [31:0] v,
                                                input logic [cau_pkg::TOL_W-1:0] tol);
        logic signed [31:0] d;
        case ($urandom_range(0, 3))
            0: d = $signed(32'(tol));
            1: d = $signed(32'(tol)) - 32'sd1;
            default: d = $signed($urandom_range(0, 200)) - 100;
        endcase
        return $urandom_range(0, 1) ? v + d : v - d;
    endfunction

    function automatic cau_pkg::cmd_t rand_cmd(input logic [cau_pkg::TOL_W-1:0] tol);
        cau_pkg::cmd_t c;
        c.operation = $urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        c.a_re = rand_val();
        c.a_im = rand_val();
        c.b_re = rand_val();
        c.b_im = rand_val();
        if (c.operation == cau_pkg::OP_CMP && $urandom_range(0, 3) != 0)
        begin
            c.b_re = near(c.a_re, tol);
            c.b_im = $urandom_range(0, 3) == 0 ? rand_val() : near(c.a_im, tol);
        end
        if (c.operation == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0)
        begin
            c.b_re = '0;
            c.b_im = '0;
        end
        return c;
    endfunction

    // hold start high across a burst; lower it only for a gap or to drain
    task automatic send_beat(input cau_pkg::cmd_t c, input bit typed, input cau_pkg::res_t r);
        cmd <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(typed ? r : predict_result(c, tolerance));
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (cau_pkg::PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [cau_pkg::TOL_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tolerance = v;
    endtask

    task automatic random_phase(input int n);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                gap = $urandom_range(0, 12);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 40);
            end
            send_beat(rand_cmd(tolerance), 1'b0, '0);
            burst--;
        end
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                cau_pkg::res_t e;
                e = pending_results.pop_front();
                if (result.result_re !== e.result_re)
                begin
                    $error("result_re expected %h got %h", e.result_re, result.result_re);
                    errors++;
                end
                if (result.result_im !== e.result_im)
                begin
                    $error("result_im expected %h got %h", e.result_im, result.result_im);
                    errors++;
                end
                if (result.is_equal !== e.is_equal)
                begin
                    $error("is_equal expected %b got %b", e.is_equal, result.is_equal);
                    errors++;
                end
                if (result.divide_by_zero !== e.divide_by_zero)
                begin
                    $error("divide_by_zero expected %b got %b",
                           e.divide_by_zero, result.divide_by_zero);
                    errors++;
                end
                if (result.overflowed !== e.overflowed)
                begin
                    $error("overflowed expected %b got %b", e.overflowed, result.overflowed);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        directed.push_back(row(cau_pkg::OP_ADD, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
        directed.push_back(row(cau_pkg::OP_ADD, VMAX, VMAX, VMAX, VMAX, 1,
                               '{VMAX, VMAX, 0, 0, 1}));
        directed.push_back(row(cau_pkg::OP_ADD, VMIN, VMIN, VMIN, VMIN, 1,
                               '{VMIN, VMIN, 0, 0, 1}));
        directed.push_back(row(cau_pkg::OP_SUB, VMIN, VMIN, 1, 1, 1,
                               '{VMIN, VMIN, 0, 0, 1}));
        directed.push_back(row(cau_pkg::OP_SUB, VMAX, VMAX, -1, 1, 1,
                               '{VMAX, VMAX - 1, 0, 0, 1}));
        directed.push_back(row(cau_pkg::OP_MUL, ONE, 0, 32'sh12345, -32'sh6789, 0, '0));
        directed.push_back(row(cau_pkg::OP_MUL, VMAX, VMAX, VMAX, VMAX, 0, '0));
        directed.push_back(row(cau_pkg::OP_MUL, VMIN, VMIN, VMIN, VMIN, 0, '0));
        directed.push_back(row(cau_pkg::OP_MUL, VMIN, 0, VMIN, 0, 0, '0));
        directed.push_back(row(cau_pkg::OP_MUL, -1, 0, 1, 0, 0, '0));
        directed.push_back(row(cau_pkg::OP_DIV, 32'sh5555, -7, 0, 0, 1, '{0, 0, 0, 1, 0}));
        directed.push_back(row(cau_pkg::OP_DIV, VMIN, VMAX, 0, 0, 1, '{0, 0, 0, 1, 0}));
        directed.push_back(row(cau_pkg::OP_DIV, ONE, 0, ONE, 0, 0, '0));
        directed.push_back(row(cau_pkg::OP_DIV, VMAX, VMAX, 1, 0, 0, '0));
        directed.push_back(row(cau_pkg::OP_DIV, VMIN, VMIN, VMIN, VMIN, 0, '0));
        directed.push_back(row(cau_pkg::OP_DIV, 1, 0, VMAX, VMAX, 0, '0));
        directed.push_back(row(cau_pkg::OP_DIV, -1, 3, VMIN, 1, 0, '0));
        directed.push_back(row(cau_pkg::OP_CMP, 123, -5, 123, -5, 1, '{0, 0, 1, 0, 0}));
        directed.push_back(row(cau_pkg::OP_CMP, 100, 0, 35, -65, 1, '{0, 0, 1, 0, 0}));
        directed.push_back(row(cau_pkg::OP_CMP, 100, 0, 34, 0, 1, '{0, 0, 0, 0, 0}));
        directed.push_back(row(cau_pkg::OP_CMP, VMAX, VMIN, VMIN, VMAX, 1,
                               '{0, 0, 0, 0, 0}));
        directed.push_back(row(OP_RSV5, VMAX, VMIN, VMAX, 7, 1, '{0, 0, 0, 0, 0}));
        directed.push_back(row(OP_RSV6, 5, 5, 0, 0, 1, '{0, 0, 0, 0, 0}));
        directed.push_back(row(OP_RSV7, VMIN, VMIN, VMIN, VMIN, 1, '{0, 0, 0, 0, 0}));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_beat(directed[i].c, directed[i].typed, directed[i].r);
            maybe_gap();
        end
        random_phase(RAND_PER_PHASE);

        write_tolerance('0);
        random_phase(RAND_PER_PHASE);
        write_tolerance(31'h7fffffff);
        random_phase(RAND_PER_PHASE);
        write_tolerance(31'd1);
        random_phase(RAND_PER_PHASE);
        write_tolerance(31'($urandom));
        random_phase(RAND_PER_PHASE / 2);
        write_tolerance(31'($urandom_range(0, 1000)));
        random_phase(RAND_PER_PHASE / 2);

        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
